// ===== hw/rtl/bso_pkg.sv =====
// Package for the band-limited sawtooth oscillator: widths, reset values,
// register indexes, polynomial coefficients and the sequencer state type.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package bso_pkg;

  // Default structural limits for the top level.
  localparam int unsigned MAX_HARMONICS_DEF    = 64;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
  localparam int unsigned MAX_CHANNELS_DEF     = 8;

  // Payload and register widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned PEAK_W     = 17;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned HCOUNT_W   = 7;
  localparam int unsigned CCOUNT_W   = 4;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Accumulator width: enough for the unsaturated sum of up to 256 harmonics.
  localparam int unsigned ACC_W = 20;

  // Restoring divider: 34-bit dividend, one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = 34;
  localparam int unsigned DIV_CNT_W = 6;

  // Register reset values.
  localparam logic                MODE_RST   = 1'b0;
  localparam logic [PHASE_W-1:0]  STEP_RST   = '0;
  localparam logic [HCOUNT_W-1:0] HCOUNT_RST = 7'd1;
  localparam logic [CCOUNT_W-1:0] CCOUNT_RST = 4'd1;
  localparam logic [AMP_W-1:0]    AMP_RST    = 15'd32767;

  // Mode and pass codes.
  localparam logic MODE_BANDLIMITED = 1'b0;
  localparam logic MODE_NAIVE       = 1'b1;
  localparam logic OP_MEASURE       = 1'b0;
  localparam logic OP_OUTPUT        = 1'b1;

  // Fixed-point constants.
  localparam int unsigned WEIGHT_ONE  = 65536;
  localparam int unsigned QUARTER_ONE = 32768;
  localparam int unsigned SINE_MAX    = 32767;
  localparam int unsigned SUM_LIMIT   = 131071;
  localparam int unsigned POLY_C0     = 153;
  localparam int unsigned POLY_C1     = 2611;
  localparam int unsigned POLY_C2     = 21167;
  localparam int unsigned POLY_C3     = 51472;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_PHASE_STEP = 3'd1,
    REG_HCOUNT     = 3'd2,
    REG_CCOUNT     = 3'd3,
    REG_AMPLITUDE  = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NAIVE_LO,
    ST_NAIVE_HI,
    ST_NAIVE_SUM,
    ST_U2,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_SINE,
    ST_TERM,
    ST_ACC,
    ST_SUM,
    ST_NUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_SAT,
    ST_FINISH
  } bso_state_e;

endpackage

// ===== hw/rtl/bso_if.sv =====
// Channel interfaces of the band-limited sawtooth oscillator: input slots,
// result samples and configuration writes, each with valid/ready.
// Depends on bso_pkg for the payload widths.
`timescale 1ns / 1ps

interface bso_in_if;
  logic valid;
  logic ready;
  logic op;
  logic restart;

  modport source (output valid, output op, output restart, input ready);
  modport sink (input valid, input op, input restart, output ready);
endinterface

interface bso_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bso_pkg::SAMPLE_W-1:0]   sample;
  logic        [bso_pkg::CHAN_W-1:0]     channel;
  logic        [bso_pkg::PEAK_W-1:0]     peak;

  modport source (output valid, output sample, output channel, output peak, input ready);
  modport sink (input valid, input sample, input channel, input peak, output ready);
endinterface

interface bso_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bso_pkg::CFG_IDX_W-1:0]     index;
  logic [bso_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bandlimited_saw_oscillator.sv =====
// Each harmonic runs U2, T1, T2, T3 and SINE for the sine polynomial, TERM for the
// 1/k weight and ACC to accumulate; the multiplies share one 17x17 multiplier. An
// output pass with a nonzero peak then scales with a restoring divider; a naive
// ramp runs NAIVE_LO, NAIVE_HI and NAIVE_SUM instead. One slot is in work at a
// time; the output register lets a new slot start while the previous result
// waits. Reset is asynchronous.
`timescale 1ns / 1ps

module bandlimited_saw_oscillator #(
  parameter int unsigned MAX_HARMONICS    = bso_pkg::MAX_HARMONICS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = bso_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int unsigned MAX_CHANNELS     = bso_pkg::MAX_CHANNELS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bso_in_if.sink         in_i,
  bso_out_if.source      out_o,
  bso_cfg_if.sink        cfg_i
);

  // Sine quantisation: the table depth is a power of two, so the index is the
  // top bits of the phase and the quarter-wave position a shifted low part.
  localparam int unsigned SineBits = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned KBits    = $clog2(MAX_HARMONICS + 1);
  localparam int unsigned WIdxBits = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int unsigned HCmpW    = (KBits > bso_pkg::HCOUNT_W) ? KBits : bso_pkg::HCOUNT_W;
  localparam int unsigned SlotBits = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Configuration registers.
  logic                             mode_q;
  logic [bso_pkg::PHASE_W-1:0]      step_q;
  logic [bso_pkg::HCOUNT_W-1:0]     hcount_q;
  logic [bso_pkg::CCOUNT_W-1:0]     ccount_q;
  logic [bso_pkg::AMP_W-1:0]        amp_q;

  // Oscillator state.
  bso_pkg::bso_state_e              state_q, state_d;
  logic [bso_pkg::PHASE_W-1:0]      phase_q, phase_d;
  logic [SlotBits-1:0]              slot_q, slot_d;
  logic [bso_pkg::PEAK_W-1:0]       peak_q, peak_d;
  logic                             out_valid_q, out_valid_d;

  // Working registers of the sequencer.
  logic                             op_q, op_d;
  logic [bso_pkg::PHASE_W-1:0]      ph_acc_q, ph_acc_d;
  logic [KBits-1:0]                 k_q, k_d;
  logic [15:0]                      u_q, u_d;
  logic [15:0]                      u2_q, u2_d;
  logic [15:0]                      t_q, t_d;
  logic [14:0]                      s_q, s_d;
  logic                             quad_hi_q, quad_hi_d;
  logic [16:0]                      term_q, term_d;
  logic                             term_neg_q, term_neg_d;
  logic signed [bso_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [bso_pkg::PEAK_W-1:0]       sum_mag_q, sum_mag_d;
  logic                             sum_neg_q, sum_neg_d;
  logic [14:0]                      lo_q, lo_d;
  logic [31:0]                      prod_q, prod_d;
  logic [33:0]                      num_q, num_d;
  logic [18:0]                      rem_q, rem_d;
  logic [bso_pkg::DIV_CNT_W-1:0]    div_cnt_q, div_cnt_d;
  logic signed [bso_pkg::SAMPLE_W-1:0] sample_q, sample_d;

  // Output register.
  logic signed [bso_pkg::SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic [bso_pkg::CHAN_W-1:0]       out_chan_q, out_chan_d;
  logic [bso_pkg::PEAK_W-1:0]       out_peak_q, out_peak_d;

  // Combinational helpers.
  logic                             in_acc;
  logic                             out_free;
  logic [HCmpW-1:0]                 h_eff;
  logic [4:0]                       cc_eff;
  logic [SineBits-1:0]              sine_idx;
  logic [1:0]                       quad;
  logic [15:0]                      u_raw;
  logic [15:0]                      u_c;
  logic [16:0]                      weight_tab [MAX_HARMONICS];
  logic [KBits-1:0]                 k_minus1;
  logic [16:0]                      weight;
  logic [16:0]                      mul_a, mul_b;
  logic [33:0]                      mul_p;
  logic [18:0]                      p15;
  logic [bso_pkg::ACC_W-1:0]        acc_abs;
  logic [bso_pkg::PEAK_W-1:0]       sum_mag_c;
  logic [18:0]                      rem_sh;
  logic [18:0]                      den;
  logic [31:0]                      ramp_sum;

  // Harmonic weights round(65536 / k), worked out at elaboration.
  for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_weight
    localparam int unsigned Wt = (bso_pkg::WEIGHT_ONE + (g + 1) / 2) / (g + 1);
    assign weight_tab[g] = 17'(Wt);
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign h_eff = (HCmpW'(hcount_q) > HCmpW'(MAX_HARMONICS)) ? HCmpW'(MAX_HARMONICS)
                                                             : HCmpW'(hcount_q);
  assign cc_eff = (ccount_q == '0) ? 5'd1
                : (5'(ccount_q) > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : 5'(ccount_q);

  assign sine_idx = ph_acc_q[bso_pkg::PHASE_W-1 -: SineBits];
  assign quad     = sine_idx[SineBits-1 -: 2];
  assign u_raw    = 16'(sine_idx[SineBits-3:0]) << (17 - SineBits);
  assign u_c      = quad[0] ? 16'(17'(bso_pkg::QUARTER_ONE) - 17'(u_raw)) : u_raw;

  assign k_minus1 = k_q - KBits'(1);
  assign weight   = weight_tab[k_minus1[WIdxBits-1:0]];

  // The one shared multiplier; its operands follow the sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      bso_pkg::ST_NAIVE_LO: begin
        mul_a = 17'(amp_q);
        mul_b = 17'(phase_q[15:0]);
      end
      bso_pkg::ST_NAIVE_HI: begin
        mul_a = 17'(amp_q);
        mul_b = 17'(phase_q[31:16]);
      end
      bso_pkg::ST_U2: begin
        mul_a = 17'(u_c);
        mul_b = 17'(u_c);
      end
      bso_pkg::ST_T1: begin
        mul_a = 17'(u2_q);
        mul_b = 17'(bso_pkg::POLY_C0);
      end
      bso_pkg::ST_T2, bso_pkg::ST_T3: begin
        mul_a = 17'(u2_q);
        mul_b = 17'(t_q);
      end
      bso_pkg::ST_SINE: begin
        mul_a = 17'(u_q);
        mul_b = 17'(t_q);
      end
      bso_pkg::ST_TERM: begin
        mul_a = 17'(s_q);
        mul_b = weight;
      end
      bso_pkg::ST_NUM: begin
        mul_a = sum_mag_q;
        mul_b = 17'(amp_q);
      end
      default: begin
      end
    endcase
  end

  assign mul_p = 34'(mul_a) * 34'(mul_b);
  assign p15   = mul_p[33:15];

  assign acc_abs   = acc_q[bso_pkg::ACC_W-1] ? bso_pkg::ACC_W'(-acc_q)
                                             : bso_pkg::ACC_W'(acc_q);
  assign sum_mag_c = (acc_abs > bso_pkg::ACC_W'(bso_pkg::SUM_LIMIT))
                   ? bso_pkg::PEAK_W'(bso_pkg::SUM_LIMIT) : acc_abs[bso_pkg::PEAK_W-1:0];

  assign rem_sh   = {rem_q[17:0], num_q[33]};
  assign den      = {1'b0, peak_q, 1'b0};
  assign ramp_sum = prod_q + 32'(lo_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bso_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (mode_q == bso_pkg::MODE_NAIVE) begin
            state_d = bso_pkg::ST_NAIVE_LO;
          end else if (h_eff == '0) begin
            state_d = bso_pkg::ST_SUM;
          end else begin
            state_d = bso_pkg::ST_U2;
          end
        end
      end
      bso_pkg::ST_NAIVE_LO:  state_d = bso_pkg::ST_NAIVE_HI;
      bso_pkg::ST_NAIVE_HI:  state_d = bso_pkg::ST_NAIVE_SUM;
      bso_pkg::ST_NAIVE_SUM: state_d = bso_pkg::ST_FINISH;
      bso_pkg::ST_U2:        state_d = bso_pkg::ST_T1;
      bso_pkg::ST_T1:        state_d = bso_pkg::ST_T2;
      bso_pkg::ST_T2:        state_d = bso_pkg::ST_T3;
      bso_pkg::ST_T3:        state_d = bso_pkg::ST_SINE;
      bso_pkg::ST_SINE:      state_d = bso_pkg::ST_TERM;
      bso_pkg::ST_TERM:      state_d = bso_pkg::ST_ACC;
      bso_pkg::ST_ACC: begin
        if (HCmpW'(k_q) == h_eff) begin
          state_d = bso_pkg::ST_SUM;
        end else begin
          state_d = bso_pkg::ST_U2;
        end
      end
      bso_pkg::ST_SUM: begin
        if (op_q == bso_pkg::OP_MEASURE || peak_q == '0) begin
          state_d = bso_pkg::ST_FINISH;
        end else begin
          state_d = bso_pkg::ST_NUM;
        end
      end
      bso_pkg::ST_NUM:       state_d = bso_pkg::ST_DIV_INIT;
      bso_pkg::ST_DIV_INIT:  state_d = bso_pkg::ST_DIV;
      bso_pkg::ST_DIV: begin
        if (div_cnt_q == bso_pkg::DIV_CNT_W'(bso_pkg::DIV_STEPS - 1)) begin
          state_d = bso_pkg::ST_SAT;
        end
      end
      bso_pkg::ST_SAT:       state_d = bso_pkg::ST_FINISH;
      bso_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = bso_pkg::ST_IDLE;
        end
      end
      default:               state_d = bso_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register updates for each step.
  always_comb begin
    phase_d      = phase_q;
    slot_d       = slot_q;
    peak_d       = peak_q;
    op_d         = op_q;
    ph_acc_d     = ph_acc_q;
    k_d          = k_q;
    u_d          = u_q;
    u2_d         = u2_q;
    t_d          = t_q;
    s_d          = s_q;
    quad_hi_d    = quad_hi_q;
    term_d       = term_q;
    term_neg_d   = term_neg_q;
    acc_d        = acc_q;
    sum_mag_d    = sum_mag_q;
    sum_neg_d    = sum_neg_q;
    lo_d         = lo_q;
    prod_d       = prod_q;
    num_d        = num_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    sample_d     = sample_q;
    out_sample_d = out_sample_q;
    out_chan_d   = out_chan_q;
    out_peak_d   = out_peak_q;
    out_valid_d  = out_valid_q && !out_o.ready;

    unique case (state_q)
      bso_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_d     = in_i.op;
          k_d      = KBits'(1);
          acc_d    = '0;
          ph_acc_d = in_i.restart ? '0 : phase_q;
          if (in_i.restart) begin
            phase_d = '0;
            slot_d  = '0;
            if (in_i.op == bso_pkg::OP_MEASURE) begin
              peak_d = '0;
            end
          end
        end
      end
      bso_pkg::ST_NAIVE_LO: lo_d = mul_p[30:16];
      bso_pkg::ST_NAIVE_HI: prod_d = mul_p[31:0];
      bso_pkg::ST_NAIVE_SUM: begin
        // Ramp runs from -amplitude up to just below +amplitude over one turn.
        sample_d = bso_pkg::SAMPLE_W'(18'(ramp_sum[31:15]) - 18'(amp_q));
      end
      bso_pkg::ST_U2: begin
        u_d       = u_c;
        quad_hi_d = quad[1];
        u2_d      = mul_p[30:15];
      end
      bso_pkg::ST_T1: t_d = 16'(19'(bso_pkg::POLY_C1) - p15);
      bso_pkg::ST_T2: t_d = 16'(19'(bso_pkg::POLY_C2) - p15);
      bso_pkg::ST_T3: t_d = 16'(19'(bso_pkg::POLY_C3) - p15);
      bso_pkg::ST_SINE: begin
        s_d = (p15 > 19'(bso_pkg::SINE_MAX)) ? 15'(bso_pkg::SINE_MAX) : p15[14:0];
      end
      bso_pkg::ST_TERM: begin
        // Even harmonics enter with the opposite sign.
        term_d     = p15[16:0];
        term_neg_d = quad_hi_q ^ ~k_q[0];
      end
      bso_pkg::ST_ACC: begin
        acc_d    = term_neg_q ? acc_q - bso_pkg::ACC_W'(term_q)
                              : acc_q + bso_pkg::ACC_W'(term_q);
        k_d      = k_q + KBits'(1);
        ph_acc_d = ph_acc_q + phase_q;
      end
      bso_pkg::ST_SUM: begin
        sum_mag_d = sum_mag_c;
        sum_neg_d = acc_q[bso_pkg::ACC_W-1];
        sample_d  = '0;
        if (op_q == bso_pkg::OP_MEASURE && sum_mag_c > peak_q) begin
          peak_d = sum_mag_c;
        end
      end
      bso_pkg::ST_NUM: prod_d = mul_p[31:0];
      bso_pkg::ST_DIV_INIT: begin
        // Dividend 2*|sum|*amplitude + peak over divisor 2*peak rounds to nearest.
        num_d     = {prod_q, 1'b0} + 34'(peak_q);
        rem_d     = '0;
        div_cnt_d = '0;
      end
      bso_pkg::ST_DIV: begin
        div_cnt_d = div_cnt_q + bso_pkg::DIV_CNT_W'(1);
        if (rem_sh >= den) begin
          rem_d = rem_sh - den;
          num_d = {num_q[32:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          num_d = {num_q[32:0], 1'b0};
        end
      end
      bso_pkg::ST_SAT: begin
        if (sum_neg_q) begin
          sample_d = (num_q > 34'(bso_pkg::QUARTER_ONE)) ? bso_pkg::SAMPLE_MIN
                                                         : 16'(17'd0 - num_q[16:0]);
        end else begin
          sample_d = (num_q > 34'(bso_pkg::SINE_MAX)) ? bso_pkg::SAMPLE_MAX
                                                      : 16'(num_q[15:0]);
        end
      end
      bso_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sample_d = sample_q;
          out_chan_d   = bso_pkg::CHAN_W'(slot_q);
          out_peak_d   = peak_q;
          // A slot at or past the last channel closes the frame.
          if (5'(slot_q) + 5'd1 >= cc_eff) begin
            slot_d  = '0;
            phase_d = phase_q + step_q;
          end else begin
            slot_d  = slot_q + SlotBits'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bso_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      slot_q      <= '0;
      peak_q      <= '0;
      mode_q      <= bso_pkg::MODE_RST;
      step_q      <= bso_pkg::STEP_RST;
      hcount_q    <= bso_pkg::HCOUNT_RST;
      ccount_q    <= bso_pkg::CCOUNT_RST;
      amp_q       <= bso_pkg::AMP_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      peak_q      <= peak_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (bso_pkg::cfg_reg_e'(cfg_i.index))
          bso_pkg::REG_MODE:       mode_q   <= cfg_i.data[0];
          bso_pkg::REG_PHASE_STEP: step_q   <= cfg_i.data[bso_pkg::PHASE_W-1:0];
          bso_pkg::REG_HCOUNT:     hcount_q <= cfg_i.data[bso_pkg::HCOUNT_W-1:0];
          bso_pkg::REG_CCOUNT:     ccount_q <= cfg_i.data[bso_pkg::CCOUNT_W-1:0];
          bso_pkg::REG_AMPLITUDE:  amp_q    <= cfg_i.data[bso_pkg::AMP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    ph_acc_q     <= ph_acc_d;
    k_q          <= k_d;
    u_q          <= u_d;
    u2_q         <= u2_d;
    t_q          <= t_d;
    s_q          <= s_d;
    quad_hi_q    <= quad_hi_d;
    term_q       <= term_d;
    term_neg_q   <= term_neg_d;
    acc_q        <= acc_d;
    sum_mag_q    <= sum_mag_d;
    sum_neg_q    <= sum_neg_d;
    lo_q         <= lo_d;
    prod_q       <= prod_d;
    num_q        <= num_d;
    rem_q        <= rem_d;
    div_cnt_q    <= div_cnt_d;
    sample_q     <= sample_d;
    out_sample_q <= out_sample_d;
    out_chan_q   <= out_chan_d;
    out_peak_q   <= out_peak_d;
  end

  assign in_i.ready    = (state_q == bso_pkg::ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.sample  = out_sample_q;
  assign out_o.channel = out_chan_q;
  assign out_o.peak    = out_peak_q;

endmodule
